// File: hw/rtl/mau_pkg.sv
// Shared types, opcodes and modular helper functions for the modular arithmetic unit.
package mau_pkg;

	// Width of operands, results and the modulus.
	localparam int VALUE_W = 31;

	// Modulus after reset.
	localparam logic [VALUE_W-1:0] MOD_RESET = VALUE_W'(64'd1000000007);

	// Opcodes.
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_POW = 3'd3;
	localparam logic [2:0] OP_DIV = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_MODULUS = 1'b0;
	localparam logic CFG_PRIME   = 1'b1;

	typedef logic [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic [2:0] opcode;
		value_t     operand_a;
		value_t     operand_b;
	} mau_in_t;

	typedef struct packed {
		value_t result;
		logic   error;
	} mau_out_t;

	// (a + b) mod m for a, b < m.
	function automatic value_t add_mod(input value_t a, input value_t b, input value_t m);
		logic [VALUE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[VALUE_W-1:0];
	endfunction

	// (a - b) mod m for a, b < m.
	function automatic value_t sub_mod(input value_t a, input value_t b, input value_t m);
		logic [VALUE_W:0] s;
		s = {1'b0, a} - {1'b0, b};
		if (a < b) begin
			s = s + {1'b0, m};
		end
		return s[VALUE_W-1:0];
	endfunction

endpackage

// File: hw/rtl/mau_reduce.sv
// Bit-serial restoring reduction of one value modulo the modulus, one bit per cycle.
module mau_reduce import mau_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  value_t din,
	input  value_t m,
	output logic   done,
	output value_t rem
);

	localparam int CNT_W = (VALUE_W > 1) ? $clog2(VALUE_W) : 1;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	value_t           r_q;
	value_t           d_q;
	logic [VALUE_W:0] trial;

	// Shift the next dividend bit into the remainder.
	assign trial = {r_q, d_q[VALUE_W-1]};

	// Control: count one step per dividend bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the remainder stays below m, so one subtraction restores it.
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			d_q <= din;
		end else if (busy_q) begin
			d_q <= d_q << 1;
			if (trial >= {1'b0, m}) begin
				r_q <= VALUE_W'(trial - {1'b0, m});
			end else begin
				r_q <= trial[VALUE_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

// File: hw/rtl/mau_mulmod.sv
// Shift-and-add modular multiplier, one multiplier bit per cycle, ending at its last one.
module mau_mulmod import mau_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  value_t x,
	input  value_t y,
	input  value_t m,
	output logic   done,
	output value_t prod
);

	logic   busy_q;
	logic   done_q;
	value_t acc_q;
	value_t x_q;
	value_t y_q;

	// Control: stop once no set multiplier bits remain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (y_q[VALUE_W-1:1] == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: add the doubled multiplicand where the multiplier bit is set.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			if (y_q[0]) begin
				acc_q <= add_mod(acc_q, x_q, m);
			end
			x_q <= add_mod(x_q, x_q, m);
			y_q <= y_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: hw/rtl/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: configuration, sequencer and output register.
//
//  Channel   Direction  Handshake               Payload
//  input     in         in_valid / in_ready     in_data   (opcode, operand_a, operand_b)
//  output    out        out_valid / out_ready   out_data  (result, error)
//  config    in         cfg_we                  cfg_index, cfg_data
//
// An item goes straight to the done state when the modulus is below two, the opcode is
// undefined or a divide is refused; otherwise two bit-serial reductions run, then add
// or subtract is computed directly, multiply runs the shift-and-add multiplier once, and
// power or divide run it up to twice per exponent bit.
// in_ready is high only while the sequencer is idle; a finished item waits in the
// output register, and the next one may be accepted while it waits.
// Reset sets the modulus to 1000000007 and the prime flag to one.
module modular_arithmetic_unit import mau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mau_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output mau_out_t out_data,
	input  logic     cfg_we,
	input  logic     cfg_index,
	input  value_t   cfg_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_REDA  = 4'd1;
	localparam logic [3:0] ST_REDB  = 4'd2;
	localparam logic [3:0] ST_ARITH = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_PCHK  = 4'd5;
	localparam logic [3:0] ST_PMACC = 4'd6;
	localparam logic [3:0] ST_PSQR  = 4'd7;
	localparam logic [3:0] ST_FMUL  = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	localparam value_t ONE = VALUE_W'(1);
	localparam value_t TWO = VALUE_W'(2);

	logic [3:0] state_q, state_d;
	value_t     modulus_q;
	logic       prime_q;
	logic [2:0] op_q, op_d;
	value_t     m_q, m_d;
	value_t     braw_q, braw_d;
	value_t     a_q, a_d;
	value_t     b_q, b_d;
	value_t     acc_q, acc_d;
	value_t     base_q, base_d;
	value_t     exp_q, exp_d;
	value_t     res_q, res_d;
	logic       err_q, err_d;
	logic       out_valid_q;
	mau_out_t   out_data_q;

	logic       accept;
	logic       red_start, red_done;
	value_t     red_din, red_rem;
	logic       mul_start, mul_done;
	value_t     mul_x, mul_y, mul_prod;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
			prime_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODULUS: modulus_q <= cfg_data;
				CFG_PRIME:   prime_q   <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	mau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.din    (red_din),
		.m      (m_q),
		.done   (red_done),
		.rem    (red_rem)
	);

	mau_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.m      (m_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Sequencer and operand selection for the shared units.
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		m_d       = m_q;
		braw_d    = braw_q;
		a_d       = a_q;
		b_d       = b_q;
		acc_d     = acc_q;
		base_d    = base_q;
		exp_d     = exp_q;
		res_d     = res_q;
		err_d     = err_q;
		red_start = 1'b0;
		red_din   = braw_q;
		mul_start = 1'b0;
		mul_x     = base_q;
		mul_y     = base_q;

		unique case (state_q)
			ST_IDLE: begin
				red_din = in_data.operand_a;
				if (accept) begin
					op_d   = in_data.opcode;
					m_d    = modulus_q;
					braw_d = in_data.operand_b;
					res_d  = '0;
					err_d  = 1'b0;
					if (modulus_q < TWO || in_data.opcode > OP_DIV) begin
						state_d = ST_DONE;
					end else if (in_data.opcode == OP_DIV && !prime_q) begin
						err_d   = 1'b1;
						state_d = ST_DONE;
					end else begin
						red_start = 1'b1;
						state_d   = ST_REDA;
					end
				end
			end
			ST_REDA: begin
				if (red_done) begin
					a_d       = red_rem;
					red_start = 1'b1;
					state_d   = ST_REDB;
				end
			end
			ST_REDB: begin
				if (red_done) begin
					b_d     = red_rem;
					state_d = ST_ARITH;
				end
			end
			ST_ARITH: begin
				mul_x = a_q;
				mul_y = b_q;
				case (op_q)
					OP_ADD: begin
						res_d   = add_mod(a_q, b_q, m_q);
						state_d = ST_DONE;
					end
					OP_SUB: begin
						res_d   = sub_mod(a_q, b_q, m_q);
						state_d = ST_DONE;
					end
					OP_MUL: begin
						mul_start = 1'b1;
						state_d   = ST_MUL;
					end
					OP_POW: begin
						acc_d   = ONE;
						base_d  = a_q;
						exp_d   = braw_q;
						state_d = ST_PCHK;
					end
					OP_DIV: begin
						if (b_q == '0) begin
							state_d = ST_DONE;
						end else begin
							acc_d   = ONE;
							base_d  = b_q;
							exp_d   = m_q - TWO;
							state_d = ST_PCHK;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_MUL: begin
				if (mul_done) begin
					res_d   = mul_prod;
					state_d = ST_DONE;
				end
			end
			ST_PCHK: begin
				// Square-and-multiply, least significant exponent bit first.
				if (exp_q == '0) begin
					if (op_q == OP_DIV) begin
						mul_x     = a_q;
						mul_y     = acc_q;
						mul_start = 1'b1;
						state_d   = ST_FMUL;
					end else begin
						res_d   = acc_q;
						state_d = ST_DONE;
					end
				end else if (exp_q[0]) begin
					mul_x     = acc_q;
					mul_y     = base_q;
					mul_start = 1'b1;
					state_d   = ST_PMACC;
				end else begin
					mul_start = 1'b1;
					state_d   = ST_PSQR;
				end
			end
			ST_PMACC: begin
				if (mul_done) begin
					acc_d = mul_prod;
					// The square after the top exponent bit is never used.
					if (exp_q[VALUE_W-1:1] == '0) begin
						exp_d   = '0;
						state_d = ST_PCHK;
					end else begin
						mul_start = 1'b1;
						state_d   = ST_PSQR;
					end
				end
			end
			ST_PSQR: begin
				if (mul_done) begin
					base_d  = mul_prod;
					exp_d   = exp_q >> 1;
					state_d = ST_PCHK;
				end
			end
			ST_FMUL: begin
				if (mul_done) begin
					res_d   = mul_prod;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		op_q   <= op_d;
		m_q    <= m_d;
		braw_q <= braw_d;
		a_q    <= a_d;
		b_q    <= b_d;
		acc_q  <= acc_d;
		base_q <= base_d;
		exp_q  <= exp_d;
		res_q  <= res_d;
		err_q  <= err_d;
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_data_q.result <= res_q;
			out_data_q.error  <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: verif/tb_modular_arithmetic_unit.sv
// Self-checking testbench for the modular arithmetic unit with a built-in result predictor.
module tb_modular_arithmetic_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mau_pkg::*;

	// Cycles with no transfer on any port before the run is declared hung.
	localparam int QUIET_LIMIT = 20000;
	// Longest single item (divide by a 31-bit modulus) plus margin.
	localparam int DRAIN_CYCLES = 2200;
	localparam int MAX_REPORTS = 10;

	// Idle profiles for the two channels.
	localparam int IDLE_SEND_LIGHT = 0;
	localparam int IDLE_SEND_HEAVY = 1;
	localparam int IDLE_NONE       = 2;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	mau_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	mau_out_t out_data;
	logic     cfg_we = 1'b0;
	logic     cfg_index = CFG_MODULUS;
	value_t   cfg_data = '0;

	// Testbench copy of the configuration registers.
	value_t   cur_modulus = MOD_RESET;
	logic     cur_prime = 1'b1;

	mau_in_t  alu_requests[$];
	mau_out_t expected_results[$];
	int       unaccepted = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;

	modular_arithmetic_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Square-and-multiply over every bit of the exponent; base must already be below m.
	function automatic logic [63:0] mod_power(input logic [63:0] base, input logic [63:0] expo,
			input logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] e;
		acc = 64'd1 % m;
		sq = base;
		e = expo;
		while (e != 64'd0) begin
			if (e[0]) begin
				acc = (acc * sq) % m;
			end
			sq = (sq * sq) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	// Expected result of one item under the current modulus and prime flag.
	function automatic mau_out_t predict_alu(input mau_in_t item);
		logic [63:0] m;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		mau_out_t    o;
		m = 64'(cur_modulus);
		r = '0;
		o = '0;
		if (m >= 64'd2) begin
			a = 64'(item.operand_a) % m;
			b = 64'(item.operand_b) % m;
			case (item.opcode)
				OP_ADD: r = (a + b) % m;
				OP_SUB: r = (a + m - b) % m;
				OP_MUL: r = (a * b) % m;
				OP_POW: r = mod_power(a, 64'(item.operand_b), m);
				OP_DIV: begin
					// Division needs the prime flag; a zero divisor yields zero.
					if (!cur_prime) begin
						o.error = 1'b1;
					end else if (b != 64'd0) begin
						r = (a * mod_power(b, m - 64'd2, m)) % m;
					end
				end
				default: r = '0;
			endcase
		end
		o.result = r[VALUE_W-1:0];
		return o;
	endfunction

	// Operand values biased toward zero, all ones, the modulus, its neighbor and small values.
	function automatic value_t pick_operand(input value_t m);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return m;
			3: return m - value_t'(1);
			4: return value_t'($urandom_range(0, 15));
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic enqueue_op(input logic [2:0] op, input value_t a, input value_t b);
		mau_in_t item;
		item.opcode = op;
		item.operand_a = a;
		item.operand_b = b;
		alu_requests.push_back(item);
		unaccepted++;
	endtask

	task automatic queue_random(input int count);
		logic [2:0] op;
		repeat (count) begin
			// Mostly defined opcodes, about one in ten undefined.
			if ($urandom_range(0, 19) < 18) begin
				op = 3'($urandom_range(0, 4));
			end else begin
				op = 3'($urandom_range(5, 7));
			end
			enqueue_op(op, pick_operand(cur_modulus), pick_operand(cur_modulus));
		end
	endtask

	task automatic wait_drained();
		while (unaccepted != 0 || expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input value_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MODULUS) begin
			cur_modulus = val;
		end else begin
			cur_prime = val[0];
		end
	endtask

	// Waits for the unit to go idle, then loads both registers and the idle profile.
	task automatic configure(input value_t m, input logic prime, input int profile);
		wait_drained();
		write_reg(CFG_MODULUS, m);
		write_reg(CFG_PRIME, value_t'(prime));
		case (profile)
			IDLE_SEND_LIGHT: begin
				send_idle_pct = 25;
				recv_idle_pct = 79;
			end
			IDLE_SEND_HEAVY: begin
				send_idle_pct = 79;
				recv_idle_pct = 25;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic note_mismatch(input string what, input mau_out_t want, input mau_out_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%s: expected result %0d error %0d, got result %0d error %0d",
				what, want.result, want.error, got.result, got.error);
		end
	endtask

	// Driver: presents queued items, holding each one until it is accepted.
	always @(posedge clk or negedge arst_n) begin : alu_driver
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_alu(in_data));
				unaccepted--;
			end
			if (!in_valid || in_ready) begin
				if (alu_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= alu_requests.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		mau_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected result", '0, out_data);
				end else begin
					want = expected_results.pop_front();
					if (out_data.result !== want.result || out_data.error !== want.error) begin
						note_mismatch("result mismatch", want, out_data);
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: ends the run when no port has moved for too long.
	always @(posedge clk) begin : hang_watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		value_t top;
		top = '1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Default modulus: operand extremes, wraparound, and each special case.
		configure(MOD_RESET, 1'b1, IDLE_SEND_LIGHT);
		enqueue_op(OP_ADD, top, top);
		enqueue_op(OP_ADD, MOD_RESET - value_t'(1), value_t'(1));
		enqueue_op(OP_ADD, '0, '0);
		enqueue_op(OP_SUB, '0, value_t'(1));
		enqueue_op(OP_SUB, top, '0);
		enqueue_op(OP_SUB, value_t'(5), value_t'(5));
		enqueue_op(OP_MUL, top, top);
		enqueue_op(OP_MUL, MOD_RESET - value_t'(1), MOD_RESET - value_t'(1));
		enqueue_op(OP_POW, value_t'(2), '0);
		enqueue_op(OP_POW, '0, '0);
		enqueue_op(OP_POW, top, top);
		enqueue_op(OP_POW, MOD_RESET - value_t'(1), value_t'(2));
		enqueue_op(OP_POW, MOD_RESET, value_t'(5));
		enqueue_op(OP_DIV, value_t'(1), '0);
		enqueue_op(OP_DIV, value_t'(7), MOD_RESET);
		enqueue_op(OP_DIV, top, top);
		enqueue_op(OP_DIV, value_t'(1), value_t'(2));
		enqueue_op(3'd5, top, top);
		enqueue_op(3'd6, top, value_t'(1));
		enqueue_op(3'd7, top, top);
		queue_random(40);

		// Largest modulus, then the smallest legal one.
		configure(top, 1'b1, IDLE_SEND_LIGHT);
		queue_random(40);
		configure(value_t'(2), 1'b1, IDLE_SEND_HEAVY);
		queue_random(30);

		// Composite modulus with the prime flag clear: every divide is refused.
		configure(value_t'(1000), 1'b0, IDLE_SEND_HEAVY);
		queue_random(30);

		// Moduli below two give zero for every opcode.
		configure(value_t'(1), 1'b1, IDLE_SEND_HEAVY);
		queue_random(15);
		configure('0, 1'b0, IDLE_NONE);
		queue_random(15);

		// A few small primes.
		repeat (4) begin
			case ($urandom_range(0, 5))
				0: configure(value_t'(3), 1'b1, IDLE_NONE);
				1: configure(value_t'(5), 1'b1, IDLE_NONE);
				2: configure(value_t'(7), 1'b1, IDLE_NONE);
				3: configure(value_t'(13), 1'b1, IDLE_NONE);
				4: configure(value_t'(251), 1'b1, IDLE_NONE);
				default: configure(value_t'(65521), 1'b1, IDLE_NONE);
			endcase
			queue_random(10);
		end

		// Arbitrary moduli and prime flags.
		repeat (2) begin
			configure(value_t'($urandom_range(32'h7fff_ffff, 2)), 1'($urandom), IDLE_NONE);
			queue_random(20);
		end
		configure(value_t'($urandom_range(32'h7fff_ffff, 2)), 1'b1, IDLE_NONE);
		queue_random(30);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
